@@ hw/rtl/sis_pkg.sv @@
// ----------------------------------------------------------------------------
// sis_pkg: shared types for the sorted interval set
// Request and response structs, operation and status codes, cell commands
// and the flag bundle that each cell reports to the controller.
// ----------------------------------------------------------------------------
package sis_pkg;

    localparam int MAX_INTERVALS_DEF = 64;
    localparam int HANDLE_BITS_DEF   = 32;

    // operation codes of a request
    typedef enum logic [2:0] {
        OP_INS_VALUE = 3'd0,
        OP_INS_RANGE = 3'd1,
        OP_ERASE     = 3'd2,
        OP_FIND      = 3'd3,
        OP_POP_FRONT = 3'd4,
        OP_POP_BACK  = 3'd5,
        OP_CLEAR     = 3'd6
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MERGE
    } t_state;

    // command broadcast to every cell
    typedef enum logic [3:0] {
        CMD_HOLD,
        CMD_INS_NEW,
        CMD_EXTEND,
        CMD_MERGE,
        CMD_ER_REMOVE,
        CMD_ER_TRIM,
        CMD_ER_SPLIT,
        CMD_PF_REMOVE,
        CMD_PF_TRIM,
        CMD_PB_TRIM
    } t_cmd;

    // per-cell status flags
    typedef struct packed {
        logic below;        // interval ends more than one below the value
        logic touch;        // interval overlaps or touches the span
        logic hit;          // interval holds the value
        logic hit_single;   // holding interval has one member
        logic hit_split;    // value strictly inside holding interval
        logic last_single;  // last interval has one member
        logic merge;        // marked interval reaches its right neighbor
    } t_cell_flags;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] first_value;
        logic [31:0] last_value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_value;
        logic [6:0]  interval_count;
        logic [32:0] member_count;
    } t_rsp;

endpackage

@@ hw/rtl/sis_cell.sv @@
// ----------------------------------------------------------------------------
// sis_cell: one slot of the interval chain
// Holds one closed interval, compares it against the broadcast span and
// shifts to or from its neighbors as the command asks.
// ----------------------------------------------------------------------------
module sis_cell
    import sis_pkg::*;
#(
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [HANDLE_BITS-1:0] i_a,
    input  logic [HANDLE_BITS-1:0] i_b,
    input  logic                   i_valid,
    input  logic                   i_valid_r,
    input  logic                   i_first,
    input  logic                   i_left_below,
    input  logic                   i_left_hit,
    input  logic [HANDLE_BITS-1:0] i_left_s,
    input  logic [HANDLE_BITS-1:0] i_left_e,
    input  logic [HANDLE_BITS-1:0] i_right_s,
    input  logic [HANDLE_BITS-1:0] i_right_e,
    output logic [HANDLE_BITS-1:0] o_s,
    output logic [HANDLE_BITS-1:0] o_e,
    output t_cell_flags            o_flags,
    output logic [HANDLE_BITS:0]   o_ext_delta,
    output logic [HANDLE_BITS:0]   o_mrg_delta,
    output logic [HANDLE_BITS-1:0] o_last_e
);

    localparam int HW = HANDLE_BITS;

    logic [HW-1:0] r_s, r_e, n_s, n_e;
    logic          r_mark, r_gt, n_mark, n_gt;
    logic          below, touch, is_lo, gt_lo, hit, le_a, gt_hit, is_last, merge;
    logic [HW-1:0] ext_s, ext_e, mrg_e;

    // member count of [x, y], one bit wider than a handle
    function automatic logic [HW:0] span_size(input logic [HW-1:0] x, input logic [HW-1:0] y);
        return {1'b0, y} - {1'b0, x} + (HW+1)'(1);
    endfunction

    // local compares
    always_comb begin
        below   = i_valid && (({1'b0, r_e} + (HW+1)'(1)) < {1'b0, i_a});
        touch   = i_valid && !below && ({1'b0, r_s} <= ({1'b0, i_b} + (HW+1)'(1)));
        is_lo   = !below && (i_first || i_left_below);
        gt_lo   = !below && !is_lo;
        le_a    = i_valid && (r_s <= i_a);
        hit     = le_a && (i_a <= r_e);
        gt_hit  = !le_a;
        is_last = i_valid && !i_valid_r;
        merge   = r_mark && i_valid_r
                  && ({1'b0, i_right_s} <= ({1'b0, r_e} + (HW+1)'(1)));
        ext_s   = (i_a < r_s) ? i_a : r_s;
        ext_e   = (i_b > r_e) ? i_b : r_e;
        mrg_e   = (i_right_e > r_e) ? i_right_e : r_e;
    end

    // reports to the controller
    always_comb begin
        o_flags.below       = below;
        o_flags.touch       = touch;
        o_flags.hit         = hit;
        o_flags.hit_single  = hit && (r_s == r_e);
        o_flags.hit_split   = hit && (r_s != i_a) && (r_e != i_a);
        o_flags.last_single = is_last && (r_s == r_e);
        o_flags.merge       = merge;
        o_ext_delta = (is_lo && touch) ? (span_size(ext_s, ext_e) - span_size(r_s, r_e))
                                       : '0;
        o_mrg_delta = merge ? (span_size(r_s, mrg_e) - span_size(r_s, r_e)
                               - span_size(i_right_s, i_right_e)) : '0;
        o_last_e    = is_last ? r_e : '0;
    end

    // next interval by command
    always_comb begin
        n_s    = r_s;
        n_e    = r_e;
        n_mark = r_mark;
        n_gt   = r_gt;
        unique case (i_cmd)
            CMD_INS_NEW: begin
                if (is_lo) begin
                    n_s = i_a;
                    n_e = i_b;
                end else if (gt_lo) begin
                    n_s = i_left_s;
                    n_e = i_left_e;
                end
            end
            CMD_EXTEND: begin
                if (is_lo) begin
                    n_s = ext_s;
                    n_e = ext_e;
                end
                n_mark = is_lo;
                n_gt   = gt_lo;
            end
            CMD_MERGE: begin
                if (r_mark) begin
                    n_e = mrg_e;
                end else if (r_gt) begin
                    n_s = i_right_s;
                    n_e = i_right_e;
                end
            end
            CMD_ER_REMOVE: begin
                if (hit || gt_hit) begin
                    n_s = i_right_s;
                    n_e = i_right_e;
                end
            end
            CMD_ER_TRIM: begin
                if (hit) begin
                    if (r_s == i_a) n_s = i_a + HW'(1);
                    else            n_e = i_a - HW'(1);
                end
            end
            CMD_ER_SPLIT: begin
                if (hit) begin
                    n_e = i_a - HW'(1);
                end else if (i_left_hit) begin
                    n_s = i_a + HW'(1);
                    n_e = i_left_e;
                end else if (gt_hit) begin
                    n_s = i_left_s;
                    n_e = i_left_e;
                end
            end
            CMD_PF_REMOVE: begin
                n_s = i_right_s;
                n_e = i_right_e;
            end
            CMD_PF_TRIM: begin
                if (i_first) n_s = r_s + HW'(1);
            end
            CMD_PB_TRIM: begin
                if (is_last) n_e = r_e - HW'(1);
            end
            default: begin
            end
        endcase
    end

    // interval payload
    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        r_e <= n_e;
    end

    // merge marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= 1'b0;
            r_gt   <= 1'b0;
        end else begin
            r_mark <= n_mark;
            r_gt   <= n_gt;
        end
    end

    assign o_s = r_s;
    assign o_e = r_e;

endmodule

@@ hw/rtl/sorted_interval_set_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_interval_set_unit: set of handles kept as sorted disjoint intervals
// A chain of interval cells under a small controller.
// ----------------------------------------------------------------------------
// Usage:
//   Request: raise i_start with i_req while o_busy is low; the request is
//   taken at that clock edge. o_busy stays high until the operation ends.
//   Response: o_done is high for exactly one cycle with o_rsp; the receiver
//   cannot stall it and must take it in that cycle.
// Operation steps:
//   Most operations latch the request, then take one step in which all
//   cells compare and shift in parallel. An insert that touches a held
//   interval takes the extend step, then a merge check on the chain. Each
//   further interval it swallows adds one merge step. A new request may
//   be given in the cycle o_done is high; no request is taken while
//   o_busy is high.
// Reset:
//   i_rst_n low empties the set (no intervals, no members) and returns the
//   controller to idle; no response is pending after reset. Interval
//   contents are only read below the interval count, so they need no clear.
// ----------------------------------------------------------------------------
module sorted_interval_set_unit
    import sis_pkg::*;
#(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int HANDLE_BITS   = HANDLE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int N  = MAX_INTERVALS;
    localparam int HW = HANDLE_BITS;
    localparam int CW = $clog2(N + 1);

    t_state        r_state, n_state;
    t_op           r_op;
    logic [HW-1:0] r_a, r_b, bc_b;
    logic [CW-1:0] r_count, n_count;
    logic [32:0]   r_total, n_total;
    logic          r_done, n_done;
    t_rsp          r_rsp, n_rsp;
    t_cmd          cmd;

    logic [HW-1:0] cell_s [N];
    logic [HW-1:0] cell_e [N];
    logic [HW-1:0] cell_last_e [N];
    logic [HW:0]   cell_ext [N];
    logic [HW:0]   cell_mrg [N];
    t_cell_flags   cell_flags [N];
    logic [N:0]    valid;

    logic          any_touch, any_hit, any_single, any_split, any_last_single, any_merge;
    logic [HW:0]   sum_ext, sum_mrg;
    logic [HW-1:0] last_e;

    assign bc_b = (r_op == OP_INS_VALUE) ? r_a : r_b;

    // cell chain
    for (genvar i = 0; i < N; i++) begin : g_cell
        assign valid[i] = CW'(i) < r_count;
        sis_cell #(
            .HANDLE_BITS(HW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_a         (r_a),
            .i_b         (bc_b),
            .i_valid     (valid[i]),
            .i_valid_r   (valid[i+1]),
            .i_first     (i == 0),
            .i_left_below((i == 0) ? 1'b0 : cell_flags[(i == 0) ? 0 : i-1].below),
            .i_left_hit  ((i == 0) ? 1'b0 : cell_flags[(i == 0) ? 0 : i-1].hit),
            .i_left_s    ((i == 0) ? '0 : cell_s[(i == 0) ? 0 : i-1]),
            .i_left_e    ((i == 0) ? '0 : cell_e[(i == 0) ? 0 : i-1]),
            .i_right_s   ((i == N-1) ? '0 : cell_s[(i == N-1) ? i : i+1]),
            .i_right_e   ((i == N-1) ? '0 : cell_e[(i == N-1) ? i : i+1]),
            .o_s         (cell_s[i]),
            .o_e         (cell_e[i]),
            .o_flags     (cell_flags[i]),
            .o_ext_delta (cell_ext[i]),
            .o_mrg_delta (cell_mrg[i]),
            .o_last_e    (cell_last_e[i])
        );
    end
    assign valid[N] = 1'b0;

    // gather cell reports; at most one cell drives each data field
    always_comb begin
        any_touch       = 1'b0;
        any_hit         = 1'b0;
        any_single      = 1'b0;
        any_split       = 1'b0;
        any_last_single = 1'b0;
        any_merge       = 1'b0;
        sum_ext         = '0;
        sum_mrg         = '0;
        last_e          = '0;
        for (int i = 0; i < N; i++) begin
            any_touch       = any_touch | cell_flags[i].touch;
            any_hit         = any_hit | cell_flags[i].hit;
            any_single      = any_single | cell_flags[i].hit_single;
            any_split       = any_split | cell_flags[i].hit_split;
            any_last_single = any_last_single | cell_flags[i].last_single;
            any_merge       = any_merge | cell_flags[i].merge;
            sum_ext         = sum_ext | cell_ext[i];
            sum_mrg         = sum_mrg | cell_mrg[i];
            last_e          = last_e | cell_last_e[i];
        end
    end

    // controller: next state, cell command, response
    always_comb begin
        logic [HW:0] new_size;
        logic        full;
        logic        fin;
        t_status     st;
        logic [HW-1:0] rv;
        new_size = {1'b0, bc_b} - {1'b0, r_a} + (HW+1)'(1);
        full     = r_count >= CW'(N);
        fin      = 1'b0;
        st       = ST_IGNORED;
        rv       = '0;
        n_state  = r_state;
        n_count  = r_count;
        n_total  = r_total;
        cmd      = CMD_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                fin = 1'b1;
                case (r_op)
                    OP_INS_VALUE, OP_INS_RANGE: begin
                        if (r_a == '0 || r_a > bc_b) begin
                            st = ST_IGNORED;
                        end else if (any_touch) begin
                            cmd     = CMD_EXTEND;
                            n_total = r_total + 33'(signed'(sum_ext));
                            fin     = 1'b0;
                            n_state = S_MERGE;
                        end else if (full) begin
                            st = ST_FULL;
                        end else begin
                            st      = ST_OK;
                            cmd     = CMD_INS_NEW;
                            n_count = r_count + CW'(1);
                            n_total = r_total + 33'(new_size);
                        end
                    end
                    OP_ERASE: begin
                        if (r_a == '0 || !any_hit) begin
                            st = ST_IGNORED;
                        end else if (any_single) begin
                            st      = ST_OK;
                            cmd     = CMD_ER_REMOVE;
                            n_count = r_count - CW'(1);
                            n_total = r_total - 33'(1);
                        end else if (any_split) begin
                            if (full) begin
                                st = ST_FULL;
                            end else begin
                                st      = ST_OK;
                                cmd     = CMD_ER_SPLIT;
                                n_count = r_count + CW'(1);
                                n_total = r_total - 33'(1);
                            end
                        end else begin
                            st      = ST_OK;
                            cmd     = CMD_ER_TRIM;
                            n_total = r_total - 33'(1);
                        end
                    end
                    OP_FIND: begin
                        if (r_a != '0 && any_hit) begin
                            st = ST_OK;
                            rv = r_a;
                        end
                    end
                    OP_POP_FRONT: begin
                        if (r_count == '0) begin
                            st = ST_EMPTY;
                        end else begin
                            st      = ST_OK;
                            rv      = cell_s[0];
                            n_total = r_total - 33'(1);
                            if (cell_s[0] == cell_e[0]) begin
                                cmd     = CMD_PF_REMOVE;
                                n_count = r_count - CW'(1);
                            end else begin
                                cmd = CMD_PF_TRIM;
                            end
                        end
                    end
                    OP_POP_BACK: begin
                        if (r_count == '0) begin
                            st = ST_EMPTY;
                        end else begin
                            st      = ST_OK;
                            rv      = last_e;
                            n_total = r_total - 33'(1);
                            if (any_last_single) n_count = r_count - CW'(1);
                            else                 cmd = CMD_PB_TRIM;
                        end
                    end
                    OP_CLEAR: begin
                        st      = ST_OK;
                        n_count = '0;
                        n_total = '0;
                    end
                    default: begin
                        st = ST_IGNORED;
                    end
                endcase
                if (fin) n_state = S_IDLE;
            end
            S_MERGE: begin
                if (any_merge) begin
                    cmd     = CMD_MERGE;
                    n_count = r_count - CW'(1);
                    n_total = r_total + 33'(signed'(sum_mrg));
                end else begin
                    fin     = 1'b1;
                    st      = ST_OK;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_done                 = fin;
        n_rsp.status           = st;
        n_rsp.result_value     = 32'(rv);
        n_rsp.interval_count   = 7'(n_count);
        n_rsp.member_count     = n_total;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_done  <= n_done;
        end
    end

    // request latch and response register
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_op <= t_op'(i_req.operation);
            r_a  <= HW'(i_req.first_value);
            r_b  <= HW'(i_req.last_value);
        end
        if (n_done) r_rsp <= n_rsp;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

@@ hw/rtl/sis_checker.sv @@
// ----------------------------------------------------------------------------
// sis_checker: port-level checks for the sorted interval set
// Watches requests and responses of the top level over time.
// ----------------------------------------------------------------------------
module sis_checker
    import sis_pkg::*;
#(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_done,
    input t_rsp o_rsp
);

    // a taken request makes the block busy
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("not busy after request");

    // no response in the cycle right after a request is taken
    a_no_early_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> !o_done)
        else $error("response too early");

    // the block is idle when it shows a response
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("response while busy");

    // the reported interval count never exceeds the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.interval_count <= 7'(MAX_INTERVALS)))
        else $error("interval count out of range");

    // an empty pop reports an empty set
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_EMPTY) |->
        (o_rsp.result_value == '0 && o_rsp.interval_count == '0
         && o_rsp.member_count == '0))
        else $error("empty pop with nonempty state");

endmodule

bind sorted_interval_set_unit sis_checker #(
    .MAX_INTERVALS(MAX_INTERVALS)
) u_sis_checker (.*);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sorted_interval_set_unit
// A driver issues requests from a queue and a monitor checks every response
// against a behavioral model of the interval table kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import sis_pkg::*;

    localparam int NUM_CELLS    = MAX_INTERVALS_DEF;
    localparam int RANDOM_ITEMS = 1600;
    localparam int STALL_LIMIT  = 2000;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_done;
    t_rsp o_rsp;

    sorted_interval_set_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_req  (i_req),
        .o_busy (o_busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    // model of the interval table
    logic [31:0] span_lo [NUM_CELLS];
    logic [31:0] span_hi [NUM_CELLS];
    int          span_cnt;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   error_count;
    int   accepted_reqs;
    int   checked_rsps;
    int   idle_cycles;
    int   gap_left;
    bit   gaps_on;
    bit   stim_done;
    int   op_seen [8];
    int   status_seen [4];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [32:0] model_members();
        logic [32:0] sum;
        sum = '0;
        for (int i = 0; i < span_cnt; i++) begin
            sum = sum + {1'b0, span_hi[i]} - {1'b0, span_lo[i]} + 33'd1;
        end
        return sum;
    endfunction

    function automatic void drop_spans(int pos, int cnt);
        for (int i = pos; i + cnt < span_cnt; i++) begin
            span_lo[i] = span_lo[i + cnt];
            span_hi[i] = span_hi[i + cnt];
        end
        span_cnt -= cnt;
    endfunction

    function automatic void open_span(int pos);
        for (int i = span_cnt; i > pos; i--) begin
            span_lo[i] = span_lo[i - 1];
            span_hi[i] = span_hi[i - 1];
        end
        span_cnt++;
    endfunction

    function automatic int find_span(logic [31:0] v);
        for (int i = 0; i < span_cnt; i++) begin
            if (span_lo[i] <= v && v <= span_hi[i]) return i;
        end
        return span_cnt;
    endfunction

    function automatic t_status add_span(logic [31:0] a, logic [31:0] b);
        int lo;
        int hi;
        lo = 0;
        while (lo < span_cnt && {1'b0, span_hi[lo]} + 33'd1 < {1'b0, a}) lo++;
        if (lo == span_cnt || {1'b0, span_lo[lo]} > {1'b0, b} + 33'd1) begin
            if (span_cnt >= NUM_CELLS) return ST_FULL;
            open_span(lo);
            span_lo[lo] = a;
            span_hi[lo] = b;
            return ST_OK;
        end
        hi = lo;
        while (hi + 1 < span_cnt && {1'b0, span_lo[hi + 1]} <= {1'b0, b} + 33'd1) hi++;
        if (a < span_lo[lo]) span_lo[lo] = a;
        span_hi[lo] = (span_hi[hi] > b) ? span_hi[hi] : b;
        if (hi > lo) drop_spans(lo + 1, hi - lo);
        return ST_OK;
    endfunction

    function automatic t_status remove_value(logic [31:0] v);
        int k;
        k = find_span(v);
        if (v == 0 || k == span_cnt) return ST_IGNORED;
        if (span_lo[k] == span_hi[k]) begin
            drop_spans(k, 1);
        end else if (span_lo[k] == v) begin
            span_lo[k] = v + 1;
        end else if (span_hi[k] == v) begin
            span_hi[k] = v - 1;
        end else begin
            if (span_cnt >= NUM_CELLS) return ST_FULL;
            open_span(k);
            span_hi[k] = v - 1;
            span_lo[k + 1] = v + 1;
        end
        return ST_OK;
    endfunction

    // apply one request to the model and return the response it should give
    function automatic t_rsp apply_request(t_req r);
        t_rsp    rsp;
        t_status st;
        logic [31:0] rv;
        int k;
        st = ST_IGNORED;
        rv = '0;
        case (r.operation)
            OP_INS_VALUE: begin
                if (r.first_value != 0) st = add_span(r.first_value, r.first_value);
            end
            OP_INS_RANGE: begin
                if (r.first_value != 0 && r.first_value <= r.last_value)
                    st = add_span(r.first_value, r.last_value);
            end
            OP_ERASE: st = remove_value(r.first_value);
            OP_FIND: begin
                k = find_span(r.first_value);
                if (r.first_value != 0 && k < span_cnt) begin
                    st = ST_OK;
                    rv = r.first_value;
                end
            end
            OP_POP_FRONT: begin
                if (span_cnt == 0) begin
                    st = ST_EMPTY;
                end else begin
                    st = ST_OK;
                    rv = span_lo[0];
                    if (span_lo[0] == span_hi[0]) drop_spans(0, 1);
                    else span_lo[0] = rv + 1;
                end
            end
            OP_POP_BACK: begin
                if (span_cnt == 0) begin
                    st = ST_EMPTY;
                end else begin
                    k = span_cnt - 1;
                    st = ST_OK;
                    rv = span_hi[k];
                    if (span_lo[k] == span_hi[k]) span_cnt = k;
                    else span_hi[k] = rv - 1;
                end
            end
            OP_CLEAR: begin
                span_cnt = 0;
                st = ST_OK;
            end
            default: ;
        endcase
        rsp.status         = st;
        rsp.result_value   = rv;
        rsp.interval_count = 7'(span_cnt);
        rsp.member_count   = model_members();
        return rsp;
    endfunction

    function automatic void queue_req(logic [2:0] op, logic [31:0] a, logic [31:0] b);
        t_req r;
        r.operation   = op;
        r.first_value = a;
        r.last_value  = b;
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    // random value, mostly from a narrow window so that spans meet and merge
    function automatic logic [31:0] pick_value(int mode);
        case (mode)
            0: return 32'($urandom_range(0, 300));
            1: return 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
            2: return $urandom();
            default: return 32'($urandom_range(0, 40));
        endcase
    endfunction

    // driver: hold start while a request waits, apart from random gaps; drop it when the queue runs dry
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start  <= 1'b0;
            i_req    <= '0;
            gap_left <= 0;
        end else if (!(i_start && o_busy)) begin
            if (i_start) begin
                accepted_reqs <= accepted_reqs + 1;
                op_seen[i_req.operation] <= op_seen[i_req.operation] + 1;
                expected_rsps.insert(expected_rsps.size(), apply_request(i_req));
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_start  <= 1'b0;
            end else if (gaps_on && i_start && $urandom_range(0, 7) == 0) begin
                gap_left <= $urandom_range(0, 4);
                i_start  <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_req   <= pending_reqs[0];
                i_start <= 1'b1;
                pending_reqs.delete(0);
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: every strobed response is checked against the oldest expectation
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected response %p", $time, o_rsp);
                error_count++;
            end else begin
                want = expected_rsps[0];
                expected_rsps.delete(0);
                checked_rsps++;
                status_seen[o_rsp.status]++;
                if (o_rsp.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_rsp.status);
                    error_count++;
                end
                if (o_rsp.result_value !== want.result_value) begin
                    $display("%0t: result_value expected %0h actual %0h",
                             $time, want.result_value, o_rsp.result_value);
                    error_count++;
                end
                if (o_rsp.interval_count !== want.interval_count) begin
                    $display("%0t: interval_count expected %0d actual %0d",
                             $time, want.interval_count, o_rsp.interval_count);
                    error_count++;
                end
                if (o_rsp.member_count !== want.member_count) begin
                    $display("%0t: member_count expected %0h actual %0h",
                             $time, want.member_count, o_rsp.member_count);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles with neither a request nor a response taken
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int mode;
        int op;
        logic [31:0] a;
        logic [31:0] b;
        error_count   = 0;
        accepted_reqs = 0;
        checked_rsps  = 0;
        idle_cycles   = 0;
        span_cnt      = 0;
        gaps_on       = 1'b1;
        stim_done     = 1'b0;
        i_start       = 1'b0;
        i_req         = '0;
        i_rst_n       = 1'b0;
        foreach (op_seen[i]) op_seen[i] = 0;
        foreach (status_seen[i]) status_seen[i] = 0;

        // directed: empty pops, zero and reversed inputs, extremes, merges
        queue_req(OP_POP_FRONT, 0, 0);
        queue_req(OP_POP_BACK, 0, 0);
        queue_req(OP_INS_VALUE, 0, 0);
        queue_req(OP_INS_RANGE, 0, 5);
        queue_req(OP_INS_RANGE, 9, 3);
        queue_req(OP_INS_VALUE, 32'hFFFF_FFFF, 0);
        queue_req(OP_INS_VALUE, 1, 0);
        queue_req(OP_INS_VALUE, 3, 0);
        queue_req(OP_INS_VALUE, 2, 0);
        queue_req(OP_INS_RANGE, 10, 20);
        queue_req(OP_INS_RANGE, 30, 40);
        queue_req(OP_INS_RANGE, 5, 35);
        queue_req(OP_INS_RANGE, 10, 12);
        queue_req(OP_FIND, 0, 0);
        queue_req(OP_FIND, 37, 0);
        queue_req(OP_FIND, 41, 0);
        queue_req(OP_ERASE, 0, 0);
        queue_req(OP_ERASE, 20, 0);
        queue_req(OP_ERASE, 5, 0);
        queue_req(OP_ERASE, 40, 0);
        queue_req(OP_ERASE, 100, 0);
        queue_req(OP_INS_RANGE, 1, 32'hFFFF_FFFF);
        queue_req(OP_POP_FRONT, 0, 0);
        queue_req(OP_POP_BACK, 0, 0);
        queue_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(OP_CLEAR, 0, 0);

        // fill the table with one-member intervals, then hit it while full
        for (int i = 0; i < NUM_CELLS; i++) queue_req(OP_INS_VALUE, 32'(2 * i + 2), 0);
        queue_req(OP_INS_VALUE, 1000, 0);
        queue_req(OP_INS_RANGE, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        queue_req(OP_INS_RANGE, 2, 4);
        queue_req(OP_INS_RANGE, 11, 13);
        queue_req(OP_ERASE, 2, 0);
        queue_req(OP_INS_VALUE, 3, 0);
        queue_req(OP_INS_VALUE, 3, 0);
        queue_req(OP_ERASE, 3, 0);
        queue_req(OP_INS_RANGE, 1, 200);
        queue_req(OP_CLEAR, 0, 0);

        // random: mostly inserts and erases in a narrow window, with some noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            mode = (n % 400 < 300) ? 0 : $urandom_range(0, 3);
            op   = $urandom_range(0, 99);
            a    = pick_value(mode);
            b    = ($urandom_range(0, 9) == 0) ? $urandom() : a + 32'($urandom_range(0, 12));
            if (op < 30)       queue_req(OP_INS_VALUE, a, $urandom());
            else if (op < 45)  queue_req(OP_INS_RANGE, a, b);
            else if (op < 68)  queue_req(OP_ERASE, a, $urandom());
            else if (op < 82)  queue_req(OP_FIND, a, $urandom());
            else if (op < 89)  queue_req(OP_POP_FRONT, $urandom(), $urandom());
            else if (op < 96)  queue_req(OP_POP_BACK, $urandom(), $urandom());
            else if (op < 98)  queue_req(OP_CLEAR, $urandom(), $urandom());
            else               queue_req(3'd7, $urandom(), $urandom());
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no gaps in the last stretch of requests
        wait (pending_reqs.size() < 200);
        @(posedge i_clk);
        gaps_on <= 1'b0;
        wait (pending_reqs.size() == 0 && !i_start);
        wait (expected_rsps.size() == 0);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d requests, %0d responses checked; ops ins %0d rng %0d er %0d find %0d",
                 accepted_reqs, checked_rsps, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("pops %0d/%0d, clears %0d; status ok %0d ign %0d full %0d empty %0d",
                 op_seen[4], op_seen[5], op_seen[6], status_seen[0], status_seen[1],
                 status_seen[2], status_seen[3]);
        if (error_count == 0 && expected_rsps.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
